FILE: sv/swam_pkg.sv
// Shared types and constants for the sliding window anagram matcher.
// No dependencies; used by sliding_window_anagram_match.
`default_nettype none

package swam_pkg;

	localparam int LETTER_W = 5;
	localparam int REQ_W    = 2;
	localparam int SDATA_W  = 8;
	localparam int SUSER_W  = 2;
	localparam int MDATA_W  = 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR   = 2'd0,
		REQ_PATTERN = 2'd1,
		REQ_TEXT    = 2'd2
	} req_t;

endpackage

`default_nettype wire

FILE: sv/sliding_window_anagram_match.sv
// Sliding window anagram matcher, top level.
// Depends on swam_pkg and swam_ram (text window ring).
//
//  channel | dir | handshake         | contents
//  s_*     | in  | s_tvalid/s_tready | s_tdata: letter; s_tuser: req_type
//  m_*     | out | m_tvalid/m_tready | m_tdata: window_match, found, overflow
//
// One item per cycle sustained while m_tready holds high; each item passes through
// the input register, then the result register. The ring read for the leaving
// letter is issued at accept, addressed from the next pointer and length.
// arst_n clears all control state and counters; the ring needs no clearing.
// A stalled result holds the input register, which then drops s_tready.
`default_nettype none

module sliding_window_anagram_match #(
	parameter int MAX_PATTERN = 64,
	parameter int ALPHABET    = 26
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire [swam_pkg::SDATA_W-1:0] s_tdata,  // [4:0] letter, [7:5] zero
	input  wire [swam_pkg::SUSER_W-1:0] s_tuser,  // [1:0] req_type
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [swam_pkg::MDATA_W-1:0] m_tdata  // [0] window_match, [1] found,
	                                              // [2] overflow, [7:3] zero
);

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CW = LW + 1;
	localparam int XW = swam_pkg::LETTER_W;

	// input register
	logic                        s1_valid_q;
	logic [swam_pkg::REQ_W-1:0]  req_s1;
	logic [XW-1:0]               letter_s1;
	logic                        byp_s1;
	logic [XW-1:0]               byp_letter_s1;

	// state
	logic [CW-1:0] need_q [ALPHABET];
	logic [LW-1:0] plen_q;
	logic [LW-1:0] tcount_q;
	logic [PW-1:0] ptr_q;
	logic          found_q;
	logic          ovf_q;

	// result register
	logic          m_valid_q;
	logic [2:0]    res_q;

	// next state
	logic [CW-1:0] need_d [ALPHABET];
	logic [LW-1:0] plen_d;
	logic [LW-1:0] tcount_d;
	logic [PW-1:0] ptr_d;
	logic          found_d;
	logic          ovf_d;
	logic          match;

	logic          advance;
	logic          proc;
	logic          accept;
	logic          is_clear;
	logic          is_pat;
	logic          is_text;
	logic          letter_ok;
	logic          pat_ok;
	logic          txt_go;
	logic          full;
	logic          leave_ok;
	logic          any_nonzero;
	logic [XW-1:0] ram_rd_data;
	logic [XW-1:0] leaving;
	logic [LW:0]   leave_sum;
	logic [PW-1:0] rd_addr;
	logic          wr_en;

	assign advance  = !m_valid_q || m_tready;
	assign proc     = s1_valid_q && advance;
	assign s_tready = !s1_valid_q || advance;
	assign accept   = s_tvalid && s_tready;

	assign letter_ok = int'(letter_s1) < ALPHABET;
	assign is_clear  = req_s1 == swam_pkg::REQ_CLEAR;
	assign is_pat    = (req_s1 == swam_pkg::REQ_PATTERN) && letter_ok;
	assign is_text   = (req_s1 == swam_pkg::REQ_TEXT) && letter_ok;
	assign pat_ok    = is_pat && (plen_q != LW'(MAX_PATTERN));
	assign txt_go    = is_text && (plen_q != '0);
	assign full      = tcount_q >= plen_q;
	assign leaving   = byp_s1 ? byp_letter_s1 : ram_rd_data;
	assign leave_ok  = int'(leaving) < ALPHABET;
	assign wr_en     = proc && txt_go;

	always_comb begin
		for (int i = 0; i < ALPHABET; i++) begin
			need_d[i] = need_q[i];
			if (proc) begin
				if (is_clear) begin
					need_d[i] = '0;
				end else begin
					if (pat_ok && int'(letter_s1) == i) begin
						need_d[i] = need_d[i] + CW'(1);
					end
					if (txt_go && int'(letter_s1) == i) begin
						need_d[i] = need_d[i] - CW'(1);
					end
					if (txt_go && full && leave_ok && int'(leaving) == i) begin
						need_d[i] = need_d[i] + CW'(1);
					end
				end
			end
		end
	end

	always_comb begin
		any_nonzero = 1'b0;
		for (int i = 0; i < ALPHABET; i++) begin
			any_nonzero = any_nonzero || (need_d[i] != '0);
		end
	end

	always_comb begin
		plen_d   = plen_q;
		tcount_d = tcount_q;
		ptr_d    = ptr_q;
		found_d  = found_q;
		ovf_d    = ovf_q;
		match    = 1'b0;
		if (proc) begin
			if (is_clear) begin
				plen_d   = '0;
				tcount_d = '0;
				ptr_d    = '0;
				found_d  = 1'b0;
				ovf_d    = 1'b0;
			end else if (is_pat) begin
				if (pat_ok) begin
					plen_d = plen_q + LW'(1);
				end else begin
					ovf_d = 1'b1;
				end
			end else if (is_text) begin
				if (txt_go) begin
					match = !any_nonzero;
					if (!(full && leave_ok)) begin
						tcount_d = tcount_q + LW'(1);
					end
					ptr_d = (ptr_q == PW'(MAX_PATTERN - 1)) ? '0 : ptr_q + PW'(1);
				end else begin
					match = 1'b1;
				end
				found_d = found_q || match;
			end
		end
	end

	// slot of the letter leaving the window for the item entering now
	always_comb begin
		if ((LW+1)'(ptr_d) >= (LW+1)'(plen_d)) begin
			leave_sum = (LW+1)'(ptr_d) - (LW+1)'(plen_d);
		end else begin
			leave_sum = (LW+1)'(ptr_d) + (LW+1)'(MAX_PATTERN) - (LW+1)'(plen_d);
		end
		rd_addr = leave_sum[PW-1:0];
	end

	swam_ram #(
		.WIDTH(XW),
		.DEPTH(MAX_PATTERN)
	) u_ring (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(ptr_q),
		.wr_data(letter_s1),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			byp_s1     <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				byp_s1     <= wr_en && (ptr_q == rd_addr);
			end else if (proc) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1        <= s_tuser;
			letter_s1     <= s_tdata[XW-1:0];
			byp_letter_s1 <= letter_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALPHABET; i++) begin
				need_q[i] <= '0;
			end
			plen_q   <= '0;
			tcount_q <= '0;
			ptr_q    <= '0;
			found_q  <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			for (int i = 0; i < ALPHABET; i++) begin
				need_q[i] <= need_d[i];
			end
			plen_q   <= plen_d;
			tcount_q <= tcount_d;
			ptr_q    <= ptr_d;
			found_q  <= found_d;
			ovf_q    <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_q <= {ovf_d, found_d, match};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(swam_pkg::MDATA_W - 3)'(0), res_q};

	a_tcount_le_plen: assert property (@(posedge clk) disable iff (!arst_n)
		tcount_q <= plen_q)
		else $error("window count exceeds pattern length");

	a_plen_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		plen_q <= LW'(MAX_PATTERN))
		else $error("pattern length beyond capacity");

	a_match_sets_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
		else $error("match reported without found");

	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && is_clear) |=> (plen_q == '0 && ptr_q == '0 && !found_q && !ovf_q))
		else $error("clear did not reset query state");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !advance) |-> !s_tready)
		else $error("input taken while stage is stalled");

endmodule

`default_nettype wire

FILE: sv/swam_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the text window ring of the matcher.
`default_nettype none

module swam_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 64
) (
	input  wire                                  clk,
	input  wire                                  wr_en,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire [WIDTH-1:0]                      wr_data,
	input  wire                                  rd_en,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire
